// ===== hw/rtl/fifo_queue_with_key_search_top_macros.svh =====
// Assertion helpers shared by the queue RTL.
// Each macro expects clk and rst_n to be visible in the using module.
`ifndef FIFO_QUEUE_WITH_KEY_SEARCH_TOP_MACROS_SVH
`define FIFO_QUEUE_WITH_KEY_SEARCH_TOP_MACROS_SVH

// Same-cycle implication.
`define FQKS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FQKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fqks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fqks_pkg;

    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 32;
    localparam int OUT_CNT_W = 5;

    localparam logic [1:0] CMD_ENQ    = 2'd0;
    localparam logic [1:0] CMD_DEQ    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/fqks_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Item storage: one write port and one read port, read data registered.
module fqks_store
    import fqks_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
)
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [KEY_W-1:0]     wr_key,
    input  wire logic [PAYLOAD_W-1:0] wr_payload,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [KEY_W-1:0]     rd_key,
    output logic      [PAYLOAD_W-1:0] rd_payload
);

    logic [KEY_W-1:0]     key_mem [DEPTH];
    logic [PAYLOAD_W-1:0] payload_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]     <= wr_key;
            payload_mem[wr_addr] <= wr_payload;
        end
        rd_key     <= key_mem[rd_addr];
        rd_payload <= payload_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_queue_with_key_search_top.sv =====
// FIFO queue of DEPTH items (signed key plus payload word) with search by key.
// Input channel in_valid/in_ready carries cmd, key and payload; the output
// channel out_valid/out_ready returns exactly one result per command.
// Commands: enqueue, dequeue (oldest item) and search from the front for the
// first matching key (1-based position). Every result carries occupancy and
// the empty flag as they stand after the command.
// Each command passes through its states in order: enqueue goes from S_IDLE
// to S_DONE, dequeue through S_DEQ_WAIT to S_DONE, and search through
// S_SEARCH to S_DONE, comparing N entries, where N is at most the occupancy;
// the search reads one stored key per cycle from the single read port of the
// item memory. From S_DONE the result moves into the output register, and
// in_ready returns with out_valid.
// One command is processed at a time; a new one is taken once the previous
// result has moved into the output register, so a waiting result does not
// block the next command from entering.
// If the receiver stalls, the finished result of the next command waits in
// its holding register and no further command is accepted.
// Reset empties the queue at once (head, tail and count cleared); the item
// memory itself is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_queue_with_key_search_top_macros.svh"

module fifo_queue_with_key_search_top
    import fqks_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  cmd,
    input  wire logic signed [KEY_W-1:0]     key,
    input  wire logic [PAYLOAD_W-1:0]        payload,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       status,
    output logic signed [KEY_W-1:0]          out_key,
    output logic [PAYLOAD_W-1:0]             out_payload,
    output logic [OUT_CNT_W-1:0]             position,
    output logic                             is_empty,
    output logic [OUT_CNT_W-1:0]             occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ_WAIT,
        S_SEARCH,
        S_DONE
    } state_t;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] slot);
        if (slot == AW'(DEPTH - 1))
            return '0;
        else
            return slot + 1'b1;
    endfunction

    state_t                 state_reg, state_next;
    logic [AW-1:0]          head_reg, head_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic [CW-1:0]          cmp_reg, cmp_next;
    logic [KEY_W-1:0]       key_reg, key_next;

    logic [1:0]             st_pend_reg, st_pend_next;
    logic [KEY_W-1:0]       key_pend_reg, key_pend_next;
    logic [PAYLOAD_W-1:0]   pay_pend_reg, pay_pend_next;
    logic [OUT_CNT_W-1:0]   pos_pend_reg, pos_pend_next;

    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             status_reg, status_next;
    logic [KEY_W-1:0]       out_key_reg, out_key_next;
    logic [PAYLOAD_W-1:0]   out_payload_reg, out_payload_next;
    logic [OUT_CNT_W-1:0]   position_reg, position_next;
    logic                   is_empty_reg, is_empty_next;
    logic [OUT_CNT_W-1:0]   occupancy_reg, occupancy_next;

    logic                   wr_en;
    logic [AW-1:0]          rd_addr;
    logic [KEY_W-1:0]       rd_key;
    logic [PAYLOAD_W-1:0]   rd_payload;

    fqks_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (tail_reg),
        .wr_key     (key),
        .wr_payload (payload),
        .rd_addr    (rd_addr),
        .rd_key     (rd_key),
        .rd_payload (rd_payload)
    );

    assign in_ready = (state_reg == S_IDLE);
    // During a scan the read port walks ahead of the compare by one entry.
    assign rd_addr  = (state_reg == S_SEARCH) ? slot_reg : head_reg;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        slot_next        = slot_reg;
        cmp_next         = cmp_reg;
        key_next         = key_reg;
        st_pend_next     = st_pend_reg;
        key_pend_next    = key_pend_reg;
        pay_pend_next    = pay_pend_reg;
        pos_pend_next    = pos_pend_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        out_key_next     = out_key_reg;
        out_payload_next = out_payload_reg;
        position_next    = position_reg;
        is_empty_next    = is_empty_reg;
        occupancy_next   = occupancy_reg;
        wr_en            = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next      = key;
                    st_pend_next  = ST_OK;
                    key_pend_next = '0;
                    pay_pend_next = '0;
                    pos_pend_next = '0;
                    state_next    = S_DONE;
                    case (cmd)
                        CMD_ENQ:
                        begin
                            if (count_reg == CW'(DEPTH))
                                st_pend_next = ST_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = ring_next(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                                st_pend_next = ST_EMPTY;
                            else
                            begin
                                head_next  = ring_next(head_reg);
                                count_next = count_reg - 1'b1;
                                state_next = S_DEQ_WAIT;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            st_pend_next = ST_NOTFOUND;
                            if (count_reg != '0)
                            begin
                                slot_next  = ring_next(head_reg);
                                cmp_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            st_pend_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DEQ_WAIT:
            begin
                key_pend_next = rd_key;
                pay_pend_next = rd_payload;
                state_next    = S_DONE;
            end
            S_SEARCH:
            begin
                if (rd_key == key_reg)
                begin
                    st_pend_next  = ST_OK;
                    pos_pend_next = OUT_CNT_W'(cmp_reg + 1'b1);
                    state_next    = S_DONE;
                end
                else if ((cmp_reg + 1'b1) == count_reg)
                    state_next = S_DONE;
                else
                begin
                    cmp_next  = cmp_reg + 1'b1;
                    slot_next = ring_next(slot_reg);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = st_pend_reg;
                    out_key_next     = key_pend_reg;
                    out_payload_next = pay_pend_reg;
                    position_next    = pos_pend_reg;
                    is_empty_next    = (count_reg == '0);
                    occupancy_next   = OUT_CNT_W'(count_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            slot_reg        <= '0;
            cmp_reg         <= '0;
            key_reg         <= '0;
            st_pend_reg     <= ST_OK;
            key_pend_reg    <= '0;
            pay_pend_reg    <= '0;
            pos_pend_reg    <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
            out_key_reg     <= '0;
            out_payload_reg <= '0;
            position_reg    <= '0;
            is_empty_reg    <= 1'b1;
            occupancy_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            slot_reg        <= slot_next;
            cmp_reg         <= cmp_next;
            key_reg         <= key_next;
            st_pend_reg     <= st_pend_next;
            key_pend_reg    <= key_pend_next;
            pay_pend_reg    <= pay_pend_next;
            pos_pend_reg    <= pos_pend_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
            out_key_reg     <= out_key_next;
            out_payload_reg <= out_payload_next;
            position_reg    <= position_next;
            is_empty_reg    <= is_empty_next;
            occupancy_reg   <= occupancy_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign position    = position_reg;
    assign is_empty    = is_empty_reg;
    assign occupancy   = occupancy_reg;

    `FQKS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH),
        "item count exceeds depth")
    `FQKS_ASSERT_NEXT(a_count_only_on_transfer, !(in_valid && in_ready),
        $stable(count_reg), "item count changed without an input transfer")
    `FQKS_ASSERT_NEXT(a_full_refused,
        in_valid && in_ready && cmd == CMD_ENQ && count_reg == CW'(DEPTH),
        $stable(tail_reg) && $stable(count_reg), "enqueue on a full queue changed state")
    `FQKS_ASSERT_NOW(a_scan_in_range, state_reg == S_SEARCH, cmp_reg < count_reg,
        "search compare index past the held items")

endmodule

`default_nettype wire

// ===== tb/tb_fifo_queue_with_key_search_top.sv =====
`timescale 1ns / 1ps

module tb_fifo_queue_with_key_search_top
    import fqks_pkg::*;
;

    localparam int QUEUE_DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 550;
    // The block ignores this command value but still answers it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]             status;
        logic [KEY_W-1:0]       okey;
        logic [PAYLOAD_W-1:0]   opay;
        logic [OUT_CNT_W-1:0]   pos;
        logic                   empty;
        logic [OUT_CNT_W-1:0]   occ;
    } queue_result_t;

    class queue_scoreboard;
        logic [KEY_W-1:0]     keys [QUEUE_DEPTH];
        logic [PAYLOAD_W-1:0] pays [QUEUE_DEPTH];
        int unsigned          head;
        int unsigned          tail;
        int unsigned          count;
        queue_result_t        pending [$];
        int                   errors;

        function new();
            head = 0;
            tail = 0;
            count = 0;
            errors = 0;
        endfunction

        // Applies one accepted command to the shadow queue and records its answer.
        function void note_command(logic [1:0] c, logic [KEY_W-1:0] k,
                                   logic [PAYLOAD_W-1:0] p);
            queue_result_t r;
            int unsigned   slot;
            r = '0;
            r.status = ST_OK;
            case (c)
                CMD_ENQ:
                begin
                    if (count >= QUEUE_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        keys[tail] = k;
                        pays[tail] = p;
                        tail = (tail + 1) % QUEUE_DEPTH;
                        count++;
                    end
                end
                CMD_DEQ:
                begin
                    if (count == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        r.okey = keys[head];
                        r.opay = pays[head];
                        head = (head + 1) % QUEUE_DEPTH;
                        count--;
                    end
                end
                CMD_SEARCH:
                begin
                    r.status = ST_NOTFOUND;
                    slot = head;
                    for (int n = 0; n < count; n++)
                    begin
                        if (keys[slot] == k)
                        begin
                            r.pos = OUT_CNT_W'(n + 1);
                            r.status = ST_OK;
                            break;
                        end
                        slot = (slot + 1) % QUEUE_DEPTH;
                    end
                end
                default:
                begin
                end
            endcase
            r.empty = (count == 0);
            r.occ = OUT_CNT_W'(count);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] st, logic [KEY_W-1:0] k,
                                   logic [PAYLOAD_W-1:0] p, logic [OUT_CNT_W-1:0] pos,
                                   logic empty, logic [OUT_CNT_W-1:0] occ);
            queue_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, status %h", $time, st);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                compare_field("status", 32'(want.status), 32'(st));
                compare_field("out_key", want.okey, k);
                compare_field("out_payload", want.opay, p);
                compare_field("position", 32'(want.pos), 32'(pos));
                compare_field("is_empty", 32'(want.empty), 32'(empty));
                compare_field("occupancy", 32'(want.occ), 32'(occ));
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             cmd = CMD_ENQ;
    logic signed [KEY_W-1:0] key = '0;
    logic [PAYLOAD_W-1:0]   payload = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [1:0]             status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAYLOAD_W-1:0]   out_payload;
    logic [OUT_CNT_W-1:0]   position;
    logic                   is_empty;
    logic [OUT_CNT_W-1:0]   occupancy;

    logic                   no_idle = 1'b0;
    int                     stalled_cycles = 0;
    queue_scoreboard        sb;

    fifo_queue_with_key_search_top #(.DEPTH(QUEUE_DEPTH)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .key(key),
        .payload(payload),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .out_key(out_key),
        .out_payload(out_payload),
        .position(position),
        .is_empty(is_empty),
        .occupancy(occupancy)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver side: stalls at random except during the stretch with no idling.
    always @(posedge clk)
    begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
    end

    // Every transfer on either channel is seen here with its pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_command(cmd, key, payload);
            end
            if (out_valid && out_ready)
            begin
                sb.check_result(status, out_key, out_payload, position, is_empty, occupancy);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // Presents one command and returns at the edge where its transfer happens.
    task automatic send_cmd(input logic [1:0] c, input logic [KEY_W-1:0] k,
                            input logic [PAYLOAD_W-1:0] p);
        while (!no_idle && $urandom_range(0, 99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        key <= k;
        payload <= p;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Small signed keys repeat often, so searches both hit and miss.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 11) - 6;
        endcase
    endfunction

    function automatic logic [1:0] pick_cmd(int phase);
        int roll;
        int enq_w;
        int deq_w;
        roll = $urandom_range(0, 99);
        case (phase)
            0:
            begin
                enq_w = 60;
                deq_w = 15;
            end
            1:
            begin
                enq_w = 20;
                deq_w = 55;
            end
            default:
            begin
                enq_w = 35;
                deq_w = 30;
            end
        endcase
        if (roll < enq_w)
        begin
            return CMD_ENQ;
        end
        else if (roll < enq_w + deq_w)
        begin
            return CMD_DEQ;
        end
        else if (roll < 95)
        begin
            return CMD_SEARCH;
        end
        return CMD_UNUSED;
    endfunction

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: dequeue and search both fail, the unused code is a no-op.
        send_cmd(CMD_DEQ, 32'h1234_5678, 32'hFFFF_FFFF);
        send_cmd(CMD_SEARCH, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Fill the ring completely, starting with the key extremes.
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (i == 0)
            begin
                send_cmd(CMD_ENQ, 32'h8000_0000, 32'h0000_0000);
            end
            else if (i == 1)
            begin
                send_cmd(CMD_ENQ, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            end
            else if (i == QUEUE_DEPTH - 1)
            begin
                send_cmd(CMD_ENQ, 32'hFFFF_FFFF, $urandom);
            end
            else
            begin
                send_cmd(CMD_ENQ, 32'(i * 3 - 20), $urandom);
            end
        end
        send_cmd(CMD_ENQ, 32'h0000_0001, 32'hA5A5_A5A5);
        // Searches over a full queue: last entry, first entry and a miss.
        send_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(CMD_SEARCH, 32'h8000_0000, 32'h0000_0000);
        send_cmd(CMD_SEARCH, 32'd12345, 32'h0000_0000);
        send_cmd(CMD_DEQ, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_UNUSED, 32'h0000_0000, 32'h0000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle <= (n >= 200 && n < 300);
            send_cmd(pick_cmd((n / 60) % 3), pick_key(), $urandom);
        end
        in_valid <= 1'b0;
        no_idle <= 1'b0;

        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
